// ===== rtl/core/min_priority_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// min priority queue assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define MPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mpq assertion failed");

// checked on every clock edge, reset included
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mpq assertion failed");

`else

`define MPQ_ASSERT(lbl, clk, rst, prop)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and constants of the min priority queue core
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int FREQ_W          = 31;
  localparam int OCC_W           = 9;
  localparam int DEF_QUEUE_DEPTH = 256;
  localparam int DEF_HANDLE_BITS = 9;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WORK = 1'b1
  } ctrl_state_t;

  // commands broadcast to the cell row
  typedef struct packed {
    logic ins_en;
    logic ext_en;
  } cell_ctl_t;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted row: keeps, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module mpq_cell #(
  parameter int INDEX       = 0,
  parameter int HANDLE_BITS = mpq_pkg::DEF_HANDLE_BITS,
  parameter int CNT_W       = 9
) (
  input  logic                      clk,
  input  mpq_pkg::cell_ctl_t        ctl,
  input  logic [mpq_pkg::FREQ_W-1:0] new_key,
  input  logic [HANDLE_BITS-1:0]    new_handle,
  input  logic [CNT_W-1:0]          count,
  input  logic                      left_stay,
  input  logic [mpq_pkg::FREQ_W-1:0] left_key,
  input  logic [HANDLE_BITS-1:0]    left_handle,
  input  logic [mpq_pkg::FREQ_W-1:0] right_key,
  input  logic [HANDLE_BITS-1:0]    right_handle,
  output logic [mpq_pkg::FREQ_W-1:0] key,
  output logic [HANDLE_BITS-1:0]    handle,
  output logic                      stay
);
  import mpq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_V = CNT_W'(INDEX);

  logic occupied;

  assign occupied = (count > IDX_V);
  // equal keys stay ahead of the new entry, so ties go out oldest first
  assign stay = occupied && !(key > new_key);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (!stay) begin
        if (left_stay) begin
          key    <= new_key;
          handle <= new_handle;
        end else begin
          key    <= left_key;
          handle <= left_handle;
        end
      end
    end else if (ctl.ext_en) begin
      key    <= right_key;
      handle <= right_handle;
    end
  end

endmodule

// ===== rtl/core/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl
// command sequencer, entry count and result register of the queue
// ----------------------------------------------------------------------------
module mpq_ctrl #(
  parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = mpq_pkg::DEF_HANDLE_BITS,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       operation,
  input  logic [mpq_pkg::FREQ_W-1:0] entry_freq,
  input  logic [HANDLE_BITS-1:0]     entry_handle,
  input  logic [mpq_pkg::FREQ_W-1:0] head_key,
  input  logic [HANDLE_BITS-1:0]     head_handle,
  output logic                       busy,
  output mpq_pkg::cell_ctl_t         cell_ctl,
  output logic [mpq_pkg::FREQ_W-1:0] cmd_key,
  output logic [HANDLE_BITS-1:0]     cmd_handle,
  output logic [CNT_W-1:0]           count,
  output logic                       done,
  output mpq_pkg::status_t           status,
  output logic [mpq_pkg::FREQ_W-1:0] out_freq,
  output logic [HANDLE_BITS-1:0]     out_handle,
  output logic [mpq_pkg::OCC_W-1:0]  occupancy
);
  import mpq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(QUEUE_DEPTH);

  ctrl_state_t state, state_next;
  op_t         cmd_op;
  logic        full;
  logic        empty;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign full  = (count == DEPTH_V);
  assign empty = (count == '0);

  // occupancy reports the low bits of the count
  assign occ_ext   = {{OCC_W{1'b0}}, count};
  assign occupancy = occ_ext[OCC_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_WORK;
      S_WORK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b0;
    cell_ctl.ins_en = 1'b0;
    cell_ctl.ext_en = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_WORK: begin
        busy            = 1'b1;
        cell_ctl.ins_en = (cmd_op == OP_INSERT) && !full;
        cell_ctl.ext_en = (cmd_op == OP_EXTRACT) && !empty;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_WORK);
      if (cell_ctl.ins_en) begin
        count <= count + 1'b1;
      end else if (cell_ctl.ext_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_op     <= op_t'(operation);
      cmd_key    <= entry_freq;
      cmd_handle <= entry_handle;
    end
    if (state == S_WORK) begin
      out_freq   <= '0;
      out_handle <= '0;
      if (cmd_op == OP_INSERT) begin
        status <= full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        status <= ST_EMPTY;
      end else begin
        status     <= ST_EXTRACTED;
        out_freq   <= head_key;
        out_handle <= head_handle;
      end
    end
  end

`include "min_priority_queue_core_assert.svh"

  `MPQ_ASSERT(a_work_then_done, clk, rst, (state == S_WORK) |=> done)
  `MPQ_ASSERT(a_count_in_range, clk, rst, count <= DEPTH_V)
  `MPQ_ASSERT(a_insert_counts, clk, rst,
    (done && status == ST_INSERTED) |-> (count == CNT_W'($past(count) + 1'b1)))
  `MPQ_ASSERT(a_empty_result, clk, rst,
    (done && status == ST_EMPTY) |-> (count == '0 && out_freq == '0 && out_handle == '0))

endmodule

// ===== rtl/core/min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_core
// minimum priority queue of (frequency, handle) entries on a row of cells
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It then passes through
// the cell row, with busy high: every cell compares the broadcast key
// with its own in parallel and keeps, takes the new entry or shifts, so the
// row always stays sorted with the oldest of equal keys first. The result is
// shown in the following cycle with done high for exactly that one cycle, and
// must be taken then; a new start may be given in that same cycle. A new item
// is so taken only once the last one's result is shown; the registered command
// stage stands in front of the single cell-row update. Nothing is cleared after
// reset, so items may start on the first cycle out of reset.
module min_priority_queue_core #(
  parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = mpq_pkg::DEF_HANDLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [mpq_pkg::FREQ_W-1:0] entry_freq,
  input  logic [HANDLE_BITS-1:0]     entry_handle,
  output logic                       done,
  output mpq_pkg::status_t           status,
  output logic [mpq_pkg::FREQ_W-1:0] out_freq,
  output logic [HANDLE_BITS-1:0]     out_handle,
  output logic [mpq_pkg::OCC_W-1:0]  occupancy
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cell_ctl_t               cell_ctl;
  logic [FREQ_W-1:0]       cmd_key;
  logic [HANDLE_BITS-1:0]  cmd_handle;
  logic [CNT_W-1:0]        count;

  logic [FREQ_W-1:0]       cell_key    [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0]  cell_handle [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  cell_stay;

  mpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .entry_freq   (entry_freq),
    .entry_handle (entry_handle),
    .head_key     (cell_key[0]),
    .head_handle  (cell_handle[0]),
    .busy         (busy),
    .cell_ctl     (cell_ctl),
    .cmd_key      (cmd_key),
    .cmd_handle   (cmd_handle),
    .count        (count),
    .done         (done),
    .status       (status),
    .out_freq     (out_freq),
    .out_handle   (out_handle),
    .occupancy    (occupancy)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   l_stay;
    logic [FREQ_W-1:0]      l_key;
    logic [HANDLE_BITS-1:0] l_handle;
    logic [FREQ_W-1:0]      r_key;
    logic [HANDLE_BITS-1:0] r_handle;

    // the head cell always has the new entry as its left source
    if (i == 0) begin : g_head
      assign l_stay   = 1'b1;
      assign l_key    = '0;
      assign l_handle = '0;
    end else begin : g_mid
      assign l_stay   = cell_stay[i-1];
      assign l_key    = cell_key[i-1];
      assign l_handle = cell_handle[i-1];
    end

    // the tail cell is never occupied after an extract shift
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_key    = '0;
      assign r_handle = '0;
    end else begin : g_body
      assign r_key    = cell_key[i+1];
      assign r_handle = cell_handle[i+1];
    end

    mpq_cell #(
      .INDEX       (i),
      .HANDLE_BITS (HANDLE_BITS),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk          (clk),
      .ctl          (cell_ctl),
      .new_key      (cmd_key),
      .new_handle   (cmd_handle),
      .count        (count),
      .left_stay    (l_stay),
      .left_key     (l_key),
      .left_handle  (l_handle),
      .right_key    (r_key),
      .right_handle (r_handle),
      .key          (cell_key[i]),
      .handle       (cell_handle[i]),
      .stay         (cell_stay[i])
    );
  end

endmodule

// ===== tb/min_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_priority_queue_core_tb
// drives insert and extract items into the priority queue core, keeps its own
// insertion-order queue predictor, and checks status, key, handle and occupancy of
// every result in order
// ----------------------------------------------------------------------------
module min_priority_queue_core_tb;
  import mpq_pkg::*;

  localparam int DEPTH      = DEF_QUEUE_DEPTH;
  localparam int HBITS      = DEF_HANDLE_BITS;
  localparam int CLK_PERIOD = 12;
  localparam int STALL_MAX  = 2000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  typedef struct packed {
    status_t            status;
    logic [FREQ_W-1:0]  freq;
    logic [HBITS-1:0]   handle;
    logic [OCC_W-1:0]   occupancy;
  } queue_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              operation;
  logic [FREQ_W-1:0] entry_freq;
  logic [HBITS-1:0]  entry_handle;
  logic              done;
  status_t           status;
  logic [FREQ_W-1:0] out_freq;
  logic [HBITS-1:0]  out_handle;
  logic [OCC_W-1:0]  occupancy;

  // predictor state, entries kept in insertion order
  logic [FREQ_W-1:0] held_keys [DEPTH];
  logic [HBITS-1:0]  held_handles [DEPTH];
  int                held_count;

  queue_result_t     predicted_results [$];
  int                error_count;
  int                idle_pct;
  int                stall_cycles;

  min_priority_queue_core #(
    .QUEUE_DEPTH (DEPTH),
    .HANDLE_BITS (HBITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .entry_freq   (entry_freq),
    .entry_handle (entry_handle),
    .done         (done),
    .status       (status),
    .out_freq     (out_freq),
    .out_handle   (out_handle),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic queue_result_t apply_queue_item(op_t op, logic [FREQ_W-1:0] freq,
                                                     logic [HBITS-1:0] handle);
    queue_result_t r;
    int best;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_keys[held_count]    = freq;
        held_handles[held_count] = handle;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict compare keeps the oldest of equal keys
      best = 0;
      for (int j = 1; j < held_count; j++)
        if (held_keys[best] > held_keys[j]) best = j;
      r.freq   = held_keys[best];
      r.handle = held_handles[best];
      for (int j = best + 1; j < held_count; j++) begin
        held_keys[j-1]    = held_keys[j];
        held_handles[j-1] = held_handles[j];
      end
      held_count--;
      r.status = ST_EXTRACTED;
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_item(op_t op, logic [FREQ_W-1:0] freq, logic [HBITS-1:0] handle);
    @(negedge clk);
    // idle only on cycles where the block could take an item
    while (busy) @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    entry_freq   <= freq;
    entry_handle <= handle;
    do @(posedge clk); while (busy);
    predicted_results.push_back(apply_queue_item(op, freq, handle));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] random_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FREQ_MAX;
      2, 3, 4: return FREQ_W'($urandom_range(0, 15));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  // results must be taken in the cycle they are shown
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", status));
      end else begin
        want = predicted_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (out_freq !== want.freq)
          report_mismatch($sformatf("out_freq %0h, want %0h", out_freq, want.freq));
        if (out_handle !== want.handle)
          report_mismatch($sformatf("out_handle %0h, want %0h", out_handle, want.handle));
        if (occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, want.occupancy));
      end
    end
  end

  // watchdog on cycles with no item taken and no result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("min_priority_queue_core_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic reset_block();
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_INSERT;
    entry_freq   <= '0;
    entry_handle <= '0;
    held_count   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(OP_EXTRACT, FREQ_MAX, '1);    // empty extract
    send_item(OP_INSERT, FREQ_MAX, '1);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, 31'd5, 9'd1);
    send_item(OP_INSERT, 31'd5, 9'd2);
    send_item(OP_INSERT, 31'd5, 9'd3);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);          // ties leave oldest first
    send_item(OP_INSERT, 31'd5, 9'd4);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);          // empty again
    send_item(OP_INSERT, 31'h2AAA_AAAA, 9'h155);
    send_item(OP_INSERT, 31'h5555_5555, 9'h0AA);
    send_item(OP_INSERT, 31'h2AAA_AAAA, 9'h1FF);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);
    send_item(OP_EXTRACT, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    // fill with back-to-back items, then drops on a full queue
    idle_pct = 0;
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_INSERT, random_key(), HBITS'($urandom));
    repeat (3) send_item(OP_INSERT, random_key(), HBITS'($urandom));
    idle_pct = 28;
    for (int i = 0; i < DEPTH + 1; i++)
      send_item(OP_EXTRACT, FREQ_W'($urandom), HBITS'($urandom));
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int burst = 0; burst < 25; burst++) begin
      case (burst % 3)
        0:       insert_pct = 80;
        1:       insert_pct = 50;
        default: insert_pct = 25;
      endcase
      if (burst == 12) wait_results_drained();
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) < insert_pct)
          send_item(OP_INSERT, random_key(), HBITS'($urandom));
        else
          send_item(OP_EXTRACT, FREQ_W'($urandom), HBITS'($urandom));
      end
    end
  endtask

  initial begin
    error_count = 0;
    idle_pct    = 28;
    reset_block();
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    wait_results_drained();
    repeat (6) @(posedge clk);
    if (error_count == 0)
      $display("min_priority_queue_core_tb OK");
    else
      $display("min_priority_queue_core_tb NOT OK");
    $finish;
  end

endmodule
